FILE: rtl/core/scbl_pkg.sv
// scbl_pkg: shared types, constants and arithmetic helpers for the stereo biquad lowpass
// used by scbl_lane and stereo_cascaded_biquad_lowpass_top; depends on nothing else

package scbl_pkg;

    // sample and history formats
    localparam int SAMPLE_BITS    = 24;
    localparam int GUARD_BITS     = 8;
    localparam int HIST_BITS      = SAMPLE_BITS + GUARD_BITS;

    // coefficient formats: feedback Q4.24, gain unsigned Q1.24
    localparam int COEF_FRAC_BITS = 24;
    localparam int COEF_BITS      = 28;
    localparam int GAIN_BITS      = 25;
    localparam int SEED_BITS      = 32;

    // serial multiply-accumulate widths
    localparam int MULT_BITS      = HIST_BITS + 2;
    localparam int ACC_BITS       = HIST_BITS + 5;
    localparam int LO_BITS        = COEF_BITS - COEF_FRAC_BITS;
    localparam int PROD_BITS      = ACC_BITS + LO_BITS;
    localparam int CNT_BITS       = $clog2(COEF_BITS);

    // xorshift taps
    localparam int XS_SHIFT_A     = 13;
    localparam int XS_SHIFT_B     = 17;
    localparam int XS_SHIFT_C     = 5;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_A_GAIN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_A_FB1  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_A_FB2  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_B_GAIN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_B_FB1  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_B_FB2  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DITHER_SEED  = 3'd6;

    localparam logic [SEED_BITS-1:0] SEED_RESET = 32'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [HIST_BITS-1:0]   hist_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic        [GAIN_BITS-1:0]   gain_t;
    typedef logic        [SEED_BITS-1:0]   seed_t;

    // input and result beats
    typedef struct packed {
        sample_t left_sample;
        sample_t right_sample;
    } in_beat_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
    } out_beat_t;

    // sequencer commands to a lane
    typedef struct packed {
        logic start;
        logic step;
        logic load_b;
        logic update;
    } lane_ctrl_t;

    // coefficient bits of the current serial step
    typedef struct packed {
        logic g;
        logic f1;
        logic f2;
        logic last;
    } coef_bits_t;

    // x0 + 2*x1 + x2, exact
    function automatic logic signed [MULT_BITS-1:0] tap_sum(hist_t a, hist_t b, hist_t c);
        tap_sum = MULT_BITS'(a) + (MULT_BITS'(b) <<< 1) + MULT_BITS'(c);
    endfunction

    // saturate a stage product, already floored by the fraction bits, to history width
    function automatic hist_t sat_hist(logic signed [PROD_BITS-1:0] v);
        logic [PROD_BITS-HIST_BITS:0] top;
        top = v[PROD_BITS-1:HIST_BITS-1];
        if ((&top) || !(|top))
            sat_hist = v[HIST_BITS-1:0];
        else if (v[PROD_BITS-1])
            sat_hist = {1'b1, {(HIST_BITS-1){1'b0}}};
        else
            sat_hist = {1'b0, {(HIST_BITS-1){1'b1}}};
    endfunction

    // one xorshift step
    function automatic seed_t xorshift_step(seed_t s);
        seed_t t;
        t = s ^ (s << XS_SHIFT_A);
        t = t ^ (t >> XS_SHIFT_B);
        t = t ^ (t << XS_SHIFT_C);
        xorshift_step = t;
    endfunction

    // add dither below the output lsb, floor and saturate to sample width
    function automatic sample_t dither_round(hist_t y, logic [GUARD_BITS-1:0] d);
        logic signed [HIST_BITS:0]    t;
        logic signed [SAMPLE_BITS:0]  q;
        t = (HIST_BITS+1)'(y) + (HIST_BITS+1)'(d);
        q = t[HIST_BITS:GUARD_BITS];
        if (q[SAMPLE_BITS] == q[SAMPLE_BITS-1])
            dither_round = q[SAMPLE_BITS-1:0];
        else if (q[SAMPLE_BITS])
            dither_round = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            dither_round = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

endpackage

FILE: rtl/core/scbl_lane.sv
// scbl_lane: one channel of the two-stage biquad, histories and bit-serial multiply-accumulate
// depends on scbl_pkg; driven by stereo_cascaded_biquad_lowpass_top

module scbl_lane (
    input  logic                    clk,
    input  logic                    rst_n,
    input  scbl_pkg::lane_ctrl_t    ctrl,
    input  scbl_pkg::coef_bits_t    coef,
    input  scbl_pkg::sample_t       sample,
    output scbl_pkg::hist_t         filt_out
);
    import scbl_pkg::*;

    hist_t xh1_reg, xh1_next, xh2_reg, xh2_next;
    hist_t ah1_reg, ah1_next, ah2_reg, ah2_next;
    hist_t bh1_reg, bh1_next, bh2_reg, bh2_next;
    hist_t x_reg, x_next, ya_reg, ya_next;
    hist_t m1_reg, m1_next, m2_reg, m2_next;
    logic signed [MULT_BITS-1:0] m0_reg, m0_next;
    logic signed [ACC_BITS-1:0]  hi_reg, hi_next;
    logic        [LO_BITS-1:0]   lo_reg, lo_next;

    logic signed [ACC_BITS-1:0]  term0, term1, term2, acc_sum;
    logic signed [PROD_BITS-1:0] prod;
    hist_t x_new, stage_res;

    // scaled input and the floored, saturated result of the finished stage
    always_comb
    begin
        x_new     = {sample, {GUARD_BITS{1'b0}}};
        prod      = $signed({hi_reg, lo_reg});
        stage_res = sat_hist(prod);
    end

    // partial products of this step: +g*s, -f1*y1, -f2*y2, sign bit weighted negative
    always_comb
    begin
        term0 = ACC_BITS'(0);
        term1 = ACC_BITS'(0);
        term2 = ACC_BITS'(0);
        if (coef.g)
            term0 = coef.last ? -ACC_BITS'(m0_reg) : ACC_BITS'(m0_reg);
        if (coef.f1)
            term1 = coef.last ? ACC_BITS'(m1_reg) : -ACC_BITS'(m1_reg);
        if (coef.f2)
            term2 = coef.last ? ACC_BITS'(m2_reg) : -ACC_BITS'(m2_reg);
        acc_sum = hi_reg + term0 + term1 + term2;
    end

    // operand loading and accumulator shifting
    always_comb
    begin
        x_next  = x_reg;
        ya_next = ya_reg;
        m0_next = m0_reg;
        m1_next = m1_reg;
        m2_next = m2_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (ctrl.start)
        begin
            x_next  = x_new;
            m0_next = tap_sum(x_new, xh1_reg, xh2_reg);
            m1_next = ah1_reg;
            m2_next = ah2_reg;
            hi_next = '0;
            lo_next = '0;
        end
        else if (ctrl.load_b)
        begin
            ya_next = stage_res;
            m0_next = tap_sum(stage_res, ah1_reg, ah2_reg);
            m1_next = bh1_reg;
            m2_next = bh2_reg;
            hi_next = '0;
            lo_next = '0;
        end
        else if (ctrl.step)
        begin
            hi_next = acc_sum >>> 1;
            lo_next = {acc_sum[0], lo_reg[LO_BITS-1:1]};
        end
    end

    // history shift once both stages are done
    always_comb
    begin
        xh1_next = xh1_reg;
        xh2_next = xh2_reg;
        ah1_next = ah1_reg;
        ah2_next = ah2_reg;
        bh1_next = bh1_reg;
        bh2_next = bh2_reg;
        if (ctrl.update)
        begin
            xh2_next = xh1_reg;
            xh1_next = x_reg;
            ah2_next = ah1_reg;
            ah1_next = ya_reg;
            bh2_next = bh1_reg;
            bh1_next = stage_res;
        end
    end

    // filter histories, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh1_reg <= '0;
            xh2_reg <= '0;
            ah1_reg <= '0;
            ah2_reg <= '0;
            bh1_reg <= '0;
            bh2_reg <= '0;
        end
        else
        begin
            xh1_reg <= xh1_next;
            xh2_reg <= xh2_next;
            ah1_reg <= ah1_next;
            ah2_reg <= ah2_next;
            bh1_reg <= bh1_next;
            bh2_reg <= bh2_next;
        end
    end

    // working operands and accumulator
    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        ya_reg <= ya_next;
        m0_reg <= m0_next;
        m1_reg <= m1_next;
        m2_reg <= m2_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign filt_out = bh1_reg;

endmodule

FILE: rtl/core/stereo_cascaded_biquad_lowpass_top.sv
// stereo_cascaded_biquad_lowpass_top: sequencer, coefficient registers, dither and output register
// depends on scbl_pkg and scbl_lane

// Stereo lowpass made of two cascaded direct-form-1 biquads per channel, with 8 guard bits in
// the histories and xorshift rectangular dither before truncation and saturation to 24 bits.
// Both channels run side by side in two lanes; each lane multiplies bit-serially, one coefficient
// bit per cycle, all three products of a stage at once. A frame passes from acceptance until the
// input side is ready again through accept, the first-stage run, the second-stage load, the
// second-stage run, the history update and the dither/output step, which waits for a free output
// register; the 28-bit coefficient width sets the length of both serial runs. The result waits in
// an output register while the next frame is taken. Coefficients (gain unsigned Q1.24, feedback
// Q4.24) are to be written by the user through the configuration port only while the block is
// idle, which the block leaves unenforced. A seed write restarts the dither; zero seeds it at one.

module stereo_cascaded_biquad_lowpass_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  scbl_pkg::in_beat_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output scbl_pkg::out_beat_t                   out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scbl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [scbl_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import scbl_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_STAGE_A = 6'b000010,
        ST_LOAD_B  = 6'b000100,
        ST_STAGE_B = 6'b001000,
        ST_UPDATE  = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    coef_t g_sr_reg, g_sr_next, f1_sr_reg, f1_sr_next, f2_sr_reg, f2_sr_next;

    gain_t a_gain_reg, a_gain_next, b_gain_reg, b_gain_next;
    coef_t a_fb1_reg, a_fb1_next, a_fb2_reg, a_fb2_next;
    coef_t b_fb1_reg, b_fb1_next, b_fb2_reg, b_fb2_next;
    seed_t seed_reg, seed_next, dither_reg, dither_next;

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg, out_data_next;

    logic       in_beat, out_free, step_last, is_step;
    lane_ctrl_t ctrl;
    coef_bits_t coef;
    hist_t      left_y, right_y;
    seed_t      dith_l, dith_r;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_step   = (state_reg == ST_STAGE_A) || (state_reg == ST_STAGE_B);
    assign step_last = (cnt_reg == CNT_BITS'(COEF_BITS - 1));

    // lane commands and the coefficient bits of this step
    always_comb
    begin
        ctrl.start  = in_beat;
        ctrl.step   = is_step;
        ctrl.load_b = (state_reg == ST_LOAD_B);
        ctrl.update = (state_reg == ST_UPDATE);
        coef.g      = g_sr_reg[0];
        coef.f1     = f1_sr_reg[0];
        coef.f2     = f2_sr_reg[0];
        coef.last   = step_last;
    end

    // sequencer and coefficient shift registers
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        g_sr_next  = g_sr_reg;
        f1_sr_next = f1_sr_reg;
        f2_sr_next = f2_sr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_STAGE_A;
                    cnt_next   = '0;
                    g_sr_next  = COEF_BITS'(a_gain_reg);
                    f1_sr_next = a_fb1_reg;
                    f2_sr_next = a_fb2_reg;
                end
            end
            ST_STAGE_A, ST_STAGE_B:
            begin
                cnt_next   = cnt_reg + 1'b1;
                g_sr_next  = g_sr_reg >> 1;
                f1_sr_next = f1_sr_reg >> 1;
                f2_sr_next = f2_sr_reg >> 1;
                if (step_last)
                    state_next = (state_reg == ST_STAGE_A) ? ST_LOAD_B : ST_UPDATE;
            end
            ST_LOAD_B:
            begin
                state_next = ST_STAGE_B;
                cnt_next   = '0;
                g_sr_next  = COEF_BITS'(b_gain_reg);
                f1_sr_next = b_fb1_reg;
                f2_sr_next = b_fb2_reg;
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // dither, left first, and the output register
    always_comb
    begin
        dith_l         = xorshift_step(dither_reg);
        dith_r         = xorshift_step(dith_l);
        dither_next    = dither_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_next         = 1'b1;
            out_data_next.left_out  = dither_round(left_y, dith_l[SEED_BITS-1 -: GUARD_BITS]);
            out_data_next.right_out = dither_round(right_y, dith_r[SEED_BITS-1 -: GUARD_BITS]);
            dither_next            = dith_r;
        end
        if (cfg_valid && cfg_ready && (cfg_index == CFG_DITHER_SEED))
            dither_next = (cfg_data == '0) ? SEED_RESET : cfg_data;
    end

    // configuration register writes
    always_comb
    begin
        a_gain_next = a_gain_reg;
        a_fb1_next  = a_fb1_reg;
        a_fb2_next  = a_fb2_reg;
        b_gain_next = b_gain_reg;
        b_fb1_next  = b_fb1_reg;
        b_fb2_next  = b_fb2_reg;
        seed_next   = seed_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STAGE_A_GAIN: a_gain_next = cfg_data[GAIN_BITS-1:0];
                CFG_STAGE_A_FB1:  a_fb1_next  = cfg_data[COEF_BITS-1:0];
                CFG_STAGE_A_FB2:  a_fb2_next  = cfg_data[COEF_BITS-1:0];
                CFG_STAGE_B_GAIN: b_gain_next = cfg_data[GAIN_BITS-1:0];
                CFG_STAGE_B_FB1:  b_fb1_next  = cfg_data[COEF_BITS-1:0];
                CFG_STAGE_B_FB2:  b_fb2_next  = cfg_data[COEF_BITS-1:0];
                CFG_DITHER_SEED:  seed_next   = cfg_data[SEED_BITS-1:0];
                default:          seed_next   = seed_reg;
            endcase
        end
    end

    // control state, configuration and dither generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            a_gain_reg    <= '0;
            a_fb1_reg     <= '0;
            a_fb2_reg     <= '0;
            b_gain_reg    <= '0;
            b_fb1_reg     <= '0;
            b_fb2_reg     <= '0;
            seed_reg      <= SEED_RESET;
            dither_reg    <= SEED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            a_gain_reg    <= a_gain_next;
            a_fb1_reg     <= a_fb1_next;
            a_fb2_reg     <= a_fb2_next;
            b_gain_reg    <= b_gain_next;
            b_fb1_reg     <= b_fb1_next;
            b_fb2_reg     <= b_fb2_next;
            seed_reg      <= seed_next;
            dither_reg    <= dither_next;
        end
    end

    // coefficient shift registers and result payload
    always_ff @(posedge clk)
    begin
        g_sr_reg     <= g_sr_next;
        f1_sr_reg    <= f1_sr_next;
        f2_sr_reg    <= f2_sr_next;
        out_data_reg <= out_data_next;
    end

    // one lane per channel
    scbl_lane u_lane_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .coef     (coef),
        .sample   (in_data.left_sample),
        .filt_out (left_y)
    );

    scbl_lane u_lane_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .coef     (coef),
        .sample   (in_data.right_sample),
        .filt_out (right_y)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/sv/scbl_frame_checker.sv
// scbl_frame_checker: watches the frame, result and register channels of the stereo biquad
// lowpass, predicts each filtered frame bit for bit and compares it; depends on scbl_pkg
`timescale 1ns / 100ps

module scbl_frame_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  scbl_pkg::in_beat_t                    in_data,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  scbl_pkg::out_beat_t                   out_data,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [scbl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [scbl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output int                                    fail_count,
    output int                                    pending
);
    import scbl_pkg::*;

    localparam int LEFT_BASE  = 0;
    localparam int RIGHT_BASE = 2;

    // coefficient copies, widened so the products stay exact
    longint gain_a, fb1_a, fb2_a;
    longint gain_b, fb1_b, fb2_b;

    // filter histories per channel: {left h1, left h2, right h1, right h2}
    longint x_hist [4];
    longint a_hist [4];
    longint b_hist [4];
    logic [SEED_BITS-1:0] dither_word;

    out_beat_t filtered_q [$];

    // clamp to a signed width
    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // one direct-form-1 section, floored by the coefficient fraction and held to history width
    function automatic longint biquad(longint x0, longint x1, longint x2, longint y1,
                                      longint y2, longint g, longint f1, longint f2);
        longint acc;
        acc = g * (x0 + 2 * x1 + x2) - f1 * y1 - f2 * y2;
        return clamp(acc >>> COEF_FRAC_BITS, HIST_BITS);
    endfunction

    // both sections, history shift and dithered truncation for one channel
    function automatic sample_t filter_channel(sample_t raw, int base);
        longint x;
        longint ya;
        longint yb;
        longint d;
        longint r;
        logic [SEED_BITS-1:0] s;
        x  = longint'(raw) * (longint'(1) <<< GUARD_BITS);
        ya = biquad(x, x_hist[base], x_hist[base+1], a_hist[base], a_hist[base+1],
                    gain_a, fb1_a, fb2_a);
        yb = biquad(ya, a_hist[base], a_hist[base+1], b_hist[base], b_hist[base+1],
                    gain_b, fb1_b, fb2_b);
        x_hist[base+1] = x_hist[base];
        x_hist[base]   = x;
        a_hist[base+1] = a_hist[base];
        a_hist[base]   = ya;
        b_hist[base+1] = b_hist[base];
        b_hist[base]   = yb;
        // xorshift advances once per channel
        s = dither_word;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        dither_word = s;
        d = s[SEED_BITS-1 -: GUARD_BITS];
        r = clamp((yb + d) >>> GUARD_BITS, SAMPLE_BITS);
        return r[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        coef_t     fb_word;
        out_beat_t want;
        if (!rst_n)
        begin
            gain_a = 0;
            fb1_a  = 0;
            fb2_a  = 0;
            gain_b = 0;
            fb1_b  = 0;
            fb2_b  = 0;
            for (int i = 0; i < 4; i++)
            begin
                x_hist[i] = 0;
                a_hist[i] = 0;
                b_hist[i] = 0;
            end
            dither_word = SEED_RESET;
            filtered_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                fb_word = cfg_data[COEF_BITS-1:0];
                case (cfg_index)
                    CFG_STAGE_A_GAIN: gain_a = cfg_data[GAIN_BITS-1:0];
                    CFG_STAGE_A_FB1:  fb1_a  = fb_word;
                    CFG_STAGE_A_FB2:  fb2_a  = fb_word;
                    CFG_STAGE_B_GAIN: gain_b = cfg_data[GAIN_BITS-1:0];
                    CFG_STAGE_B_FB1:  fb1_b  = fb_word;
                    CFG_STAGE_B_FB2:  fb2_b  = fb_word;
                    // a zero seed would lock the generator, so it starts at one
                    CFG_DITHER_SEED:  dither_word = (cfg_data == 0) ? SEED_RESET : cfg_data;
                    default: ;
                endcase
            end

            // frame beat in: left channel steps the dither first
            if (in_valid && in_ready)
            begin
                want.left_out  = filter_channel(in_data.left_sample, LEFT_BASE);
                want.right_out = filter_channel(in_data.right_sample, RIGHT_BASE);
                filtered_q.push_back(want);
            end

            // result beat out
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("result beat with no frame waiting: left_out %0d right_out %0d",
                           out_data.left_out, out_data.right_out);
                    fail_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_data.left_out !== want.left_out)
                    begin
                        $error("left_out: expected %0d, actual %0d",
                               want.left_out, out_data.left_out);
                        fail_count++;
                    end
                    if (out_data.right_out !== want.right_out)
                    begin
                        $error("right_out: expected %0d, actual %0d",
                               want.right_out, out_data.right_out);
                        fail_count++;
                    end
                end
            end
            pending = filtered_q.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
// tb: stimulus and verdict for stereo_cascaded_biquad_lowpass_top, with random idling on
// both channels; depends on scbl_pkg, the block and scbl_frame_checker
`timescale 1ns / 100ps

module tb;
    import scbl_pkg::*;

    localparam int STALL_MAX     = 13;
    localparam int RANDOM_FRAMES = 1850;
    localparam int IDLE_LIMIT    = 4000;
    localparam int END_WAIT      = 100;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    localparam sample_t SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // coefficient words
    localparam logic [31:0] GAIN_HIGH = 32'h0100_0000;
    localparam logic [31:0] GAIN_MAX  = 32'h01FF_FFFF;
    localparam logic [31:0] FB_MAX    = 32'h07FF_FFFF;
    localparam logic [31:0] FB_MIN    = 32'h0800_0000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    // butterworth sections near fs/10 and fs/4, Q4.24
    localparam int LP_A_GAIN = 1131690;
    localparam int LP_A_FB1  = -19176006;
    localparam int LP_A_FB2  = 6925635;
    localparam int LP_B_GAIN = 4913933;
    localparam int LP_B_FB1  = 0;
    localparam int LP_B_FB2  = 2878465;

    typedef enum int {SET_LOWPASS, SET_RANDOM, SET_EXTREME} setting_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    in_beat_t                    in_data;
    logic                        out_valid;
    logic                        out_ready;
    out_beat_t                   out_data;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    int      fail_count;
    int      pending;
    int      frames_sent;
    int      idle_cycles;
    bit      calm_in;
    sample_t walk_l;
    sample_t walk_r;

    stereo_cascaded_biquad_lowpass_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scbl_frame_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic in_beat_t frame(sample_t l, sample_t r);
        frame.left_sample  = l;
        frame.right_sample = r;
    endfunction

    // full range, small, rails, or a bounded random walk
    function automatic sample_t random_sample(inout sample_t walk);
        int level;
        level = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: random_sample = level[SAMPLE_BITS-1:0];
            4, 5:
            begin
                level = int'($urandom_range(0, 2000)) - 1000;
                random_sample = level[SAMPLE_BITS-1:0];
            end
            6: random_sample = SAMPLE_TOP;
            7: random_sample = SAMPLE_BOTTOM;
            default:
            begin
                level = int'(walk) + int'($urandom_range(0, 131072)) - 65536;
                if (level > int'(SAMPLE_TOP))
                    level = int'(SAMPLE_TOP);
                if (level < int'(SAMPLE_BOTTOM))
                    level = int'(SAMPLE_BOTTOM);
                walk = level[SAMPLE_BITS-1:0];
                random_sample = walk;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_fb();
        case ($urandom_range(0, 3))
            0: pick_fb = FB_MAX;
            1: pick_fb = FB_MIN;
            2: pick_fb = 32'd0;
            default: pick_fb = ALL_ONES;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 2))
            0: pick_gain = 32'd0;
            1: pick_gain = GAIN_HIGH;
            default: pick_gain = GAIN_MAX;
        endcase
    endfunction

    // one frame beat, after a random gap
    task automatic send_frame(input in_beat_t beat);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, STALL_MAX);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = beat;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        frames_sent++;
        if (frames_sent % 40 == 0 && $urandom_range(0, 2) == 0)
            calm_in = !calm_in;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [31:0] data);
        @(negedge clk);
        cfg_index = index;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic program_setting(input setting_t kind);
        case (kind)
            SET_LOWPASS:
            begin
                write_reg(CFG_STAGE_A_GAIN, LP_A_GAIN);
                write_reg(CFG_STAGE_A_FB1, LP_A_FB1);
                write_reg(CFG_STAGE_A_FB2, LP_A_FB2);
                write_reg(CFG_STAGE_B_GAIN, LP_B_GAIN);
                write_reg(CFG_STAGE_B_FB1, LP_B_FB1);
                write_reg(CFG_STAGE_B_FB2, LP_B_FB2);
                write_reg(CFG_DITHER_SEED, $urandom());
            end
            SET_RANDOM:
            begin
                // random subset, random words with garbage above the field
                if ($urandom_range(0, 1)) write_reg(CFG_STAGE_A_GAIN, $urandom());
                if ($urandom_range(0, 1)) write_reg(CFG_STAGE_A_FB1, $urandom());
                if ($urandom_range(0, 1)) write_reg(CFG_STAGE_A_FB2, $urandom());
                if ($urandom_range(0, 1)) write_reg(CFG_STAGE_B_GAIN, $urandom());
                if ($urandom_range(0, 1)) write_reg(CFG_STAGE_B_FB1, $urandom());
                if ($urandom_range(0, 1)) write_reg(CFG_STAGE_B_FB2, $urandom());
                if ($urandom_range(0, 1)) write_reg(CFG_DITHER_SEED, $urandom());
                if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_INDEX, $urandom());
            end
            default:
            begin
                write_reg(CFG_STAGE_A_GAIN, pick_gain());
                write_reg(CFG_STAGE_A_FB1, pick_fb());
                write_reg(CFG_STAGE_A_FB2, pick_fb());
                write_reg(CFG_STAGE_B_GAIN, pick_gain());
                write_reg(CFG_STAGE_B_FB1, pick_fb());
                write_reg(CFG_STAGE_B_FB2, pick_fb());
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_DITHER_SEED, 32'd0);
                    1: write_reg(CFG_DITHER_SEED, ALL_ONES);
                    default: write_reg(CFG_DITHER_SEED, 32'd1);
                endcase
            end
        endcase
    endtask

    // result side: random stall ahead of each beat, with calm stretches
    initial
    begin : result_sink
        bit calm_out;
        int stall;
        int taken;
        calm_out  = 1'b0;
        taken     = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm_out ? 0 : $urandom_range(0, STALL_MAX);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            if (taken % 40 == 0 && $urandom_range(0, 2) == 0)
                calm_out = !calm_out;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int       target;
        int       n;
        setting_t kind;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_STAGE_A_GAIN;
        cfg_data    = '0;
        calm_in     = 1'b0;
        frames_sent = 0;
        walk_l      = '0;
        walk_r      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients: the output is zero while the dither still advances
        send_frame(frame(sample_t'(0), sample_t'(0)));
        send_frame(frame(SAMPLE_TOP, SAMPLE_BOTTOM));
        send_frame(frame(SAMPLE_BOTTOM, SAMPLE_TOP));
        settle();

        // ordinary lowpass, every register plus the unused index
        write_reg(CFG_UNUSED_INDEX, ALL_ONES);
        write_reg(CFG_STAGE_A_GAIN, LP_A_GAIN);
        write_reg(CFG_STAGE_A_FB1, LP_A_FB1);
        write_reg(CFG_STAGE_A_FB2, LP_A_FB2);
        write_reg(CFG_STAGE_B_GAIN, LP_B_GAIN);
        write_reg(CFG_STAGE_B_FB1, LP_B_FB1);
        write_reg(CFG_STAGE_B_FB2, LP_B_FB2);
        write_reg(CFG_DITHER_SEED, 32'h1357_9BDF);
        send_frame(frame(sample_t'(0), sample_t'(0)));
        send_frame(frame(SAMPLE_TOP, SAMPLE_TOP));
        send_frame(frame(SAMPLE_TOP, SAMPLE_TOP));
        send_frame(frame(SAMPLE_TOP, SAMPLE_TOP));
        send_frame(frame(SAMPLE_BOTTOM, SAMPLE_BOTTOM));
        send_frame(frame(SAMPLE_BOTTOM, SAMPLE_BOTTOM));
        send_frame(frame(SAMPLE_TOP, SAMPLE_BOTTOM));
        send_frame(frame(SAMPLE_BOTTOM, SAMPLE_TOP));
        send_frame(frame(SAMPLE_TOP, SAMPLE_BOTTOM));
        send_frame(frame(sample_t'(1), sample_t'(-1)));
        send_frame(frame(sample_t'(-1), sample_t'(1)));
        settle();

        // rails: gain beyond one with masked upper bits, feedback at both ends, zero seed
        write_reg(CFG_STAGE_A_GAIN, ALL_ONES);
        write_reg(CFG_STAGE_A_FB1, FB_MAX);
        write_reg(CFG_STAGE_A_FB2, FB_MIN);
        write_reg(CFG_STAGE_B_GAIN, GAIN_HIGH);
        write_reg(CFG_STAGE_B_FB1, 32'hF800_0000);
        write_reg(CFG_STAGE_B_FB2, FB_MAX);
        write_reg(CFG_DITHER_SEED, 32'd0);
        send_frame(frame(SAMPLE_TOP, SAMPLE_BOTTOM));
        send_frame(frame(SAMPLE_BOTTOM, SAMPLE_TOP));
        send_frame(frame(SAMPLE_TOP, SAMPLE_TOP));
        send_frame(frame(SAMPLE_BOTTOM, SAMPLE_BOTTOM));
        send_frame(frame(sample_t'(0), sample_t'(0)));
        send_frame(frame(sample_t'(0), sample_t'(0)));
        settle();

        // random phases, each under a fresh setting
        target = frames_sent + RANDOM_FRAMES;
        while (frames_sent < target)
        begin
            kind = setting_t'($urandom_range(0, 2));
            program_setting(kind);
            n = $urandom_range(100, 240);
            if (n > target - frames_sent)
                n = target - frames_sent;
            repeat (n)
            begin
                send_frame(frame(random_sample(walk_l), random_sample(walk_r)));
                if ($urandom_range(0, 149) == 0)
                    settle();
            end
            settle();
        end

        repeat (END_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
